FILE: sv/nnt_pkg.sv
// ----------------------------------------------------------------------------
// nnt_pkg: shared definitions for the nearest-neighbor tour builder
// Holds the default sizes, fixed field widths, register codes, the sequencer
// state type and the tag that rides along with the distance pipeline.
// ----------------------------------------------------------------------------
package nnt_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int MaxCitiesDef = 32;
  localparam int CoordBitsDef = 16;

  // Fixed widths of the channel fields.
  localparam int CITY_W     = 6;
  localparam int COORD_IN_W = 16;
  localparam int DIST_OUT_W = 33;

  // Configuration port geometry.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // Register codes (word index on the configuration port).
  localparam logic [0:0] REG_CITY_COUNT = 1'b0;

  // Reset value of the city count register.
  localparam logic [CITY_W-1:0] CITY_COUNT_RST = 6'd32;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_LOAD,
    S_FIRST,
    S_CUR,
    S_SCAN,
    S_DRAIN,
    S_HOP,
    S_RET,
    S_RWAIT,
    S_REMIT
  } nnt_state_t;

  // Tag carried through the distance pipeline with each candidate.
  typedef struct packed {
    logic              vld;
    logic              live;
    logic [CITY_W-1:0] idx;
  } nnt_tag_t;

endpackage

FILE: sv/nnt_ram.sv
// ----------------------------------------------------------------------------
// nnt_ram: generic single-port-write, single-port-read RAM
// One write and one read address per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module nnt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/nnt_dist_unit.sv
// ----------------------------------------------------------------------------
// nnt_dist_unit: pipelined squared-distance unit
// Three register stages: absolute differences, squares, sum. Each candidate
// travels with its tag so the sequencer can match results to cities.
// ----------------------------------------------------------------------------
module nnt_dist_unit
  import nnt_pkg::*;
#(
  parameter int COORD_BITS = CoordBitsDef
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  nnt_tag_t              tag_i,
  input  logic [COORD_BITS-1:0] ax_i,
  input  logic [COORD_BITS-1:0] ay_i,
  input  logic [COORD_BITS-1:0] bx_i,
  input  logic [COORD_BITS-1:0] by_i,
  output nnt_tag_t              tag_o,
  output logic [2*COORD_BITS:0] dist_o,
  output logic                  busy_o
);

  localparam int SQ_W = 2 * COORD_BITS;

  nnt_tag_t              tag1_r, tag2_r, tag3_r;
  logic [COORD_BITS-1:0] dx_r, dy_r;
  logic [COORD_BITS-1:0] dx_nxt, dy_nxt;
  logic [SQ_W-1:0]       sqx_r, sqy_r;
  logic [SQ_W:0]         dist_r;

  // Absolute coordinate differences.
  always_comb begin
    dx_nxt = (ax_i > bx_i) ? (ax_i - bx_i) : (bx_i - ax_i);
    dy_nxt = (ay_i > by_i) ? (ay_i - by_i) : (by_i - ay_i);
  end

  // Tags of the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
    end else begin
      tag1_r <= tag_i;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
    end
  end

  // Datapath stages.
  always_ff @(posedge clk) begin
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    sqx_r  <= SQ_W'(dx_r) * SQ_W'(dx_r);
    sqy_r  <= SQ_W'(dy_r) * SQ_W'(dy_r);
    dist_r <= {1'b0, sqx_r} + {1'b0, sqy_r};
  end

  assign tag_o  = tag3_r;
  assign dist_o = dist_r;
  assign busy_o = tag1_r.vld | tag2_r.vld | tag3_r.vld;

endmodule

FILE: sv/nearest_neighbour_tour.sv
// Loading stores one city per input handshake; the last city starts a tour.
// Each hop scans cities 1 to n-1 through the single RAM read port and the
// shared distance pipeline, one candidate per cycle, then waits for the
// pipeline to drain and emits the hop, which can stall on out_ready.
// Throughput: one tour at a time; in_ready is low meanwhile.
// Reset (synchronous, active low) clears control state; city_count reads 32.
// ----------------------------------------------------------------------------
// nearest_neighbour_tour: greedy nearest-neighbor tour builder
// Stores city coordinates, then emits a tour from city 0 that always moves
// to the closest unvisited city (lowest index on a tie) and returns to city 0.
// ----------------------------------------------------------------------------
module nearest_neighbour_tour
  import nnt_pkg::*;
#(
  parameter int MAX_CITIES = MaxCitiesDef,
  parameter int COORD_BITS = CoordBitsDef
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_IN_W-1:0] in_x_coord,
  input  logic [COORD_IN_W-1:0] in_y_coord,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CITY_W-1:0]     out_city_index,
  output logic [DIST_OUT_W-1:0] out_hop_dist_sq,
  output logic                  out_tour_end,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int IW = $clog2(MAX_CITIES);
  localparam int NW = $clog2(MAX_CITIES + 1);
  localparam int RW = 2 * COORD_BITS;
  localparam int DW = 2 * COORD_BITS + 1;

  nnt_state_t            state_r, state_nxt;
  logic [CITY_W-1:0]     city_count_r;
  logic [NW-1:0]         n_eff;
  logic [NW-1:0]         load_cnt_r, load_cnt_nxt;
  logic [IW-1:0]         slot;
  logic [NW-1:0]         slot_inc;
  logic [MAX_CITIES-1:0] visited_r, visited_nxt;
  logic [COORD_BITS-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [IW-1:0]         scan_r, scan_nxt;
  logic [NW-1:0]         hop_r, hop_nxt;
  logic [DW-1:0]         best_dist_r, best_dist_nxt;
  logic [IW-1:0]         best_city_r, best_city_nxt;
  logic                  found_r, found_nxt;
  nnt_tag_t              tag_r, tag_nxt;

  // Output register.
  logic                  out_valid_r;
  logic [CITY_W-1:0]     out_city_r;
  logic [DIST_OUT_W-1:0] out_dist_r;
  logic                  out_end_r;
  logic                  out_free;
  logic                  push;
  logic [CITY_W-1:0]     push_city;
  logic [DIST_OUT_W-1:0] push_dist;
  logic                  push_end;

  // RAM and distance unit signals.
  logic                  ram_we;
  logic [IW-1:0]         ram_raddr;
  logic [RW-1:0]         ram_wdata, ram_rdata;
  logic [COORD_BITS-1:0] rd_x, rd_y;
  nnt_tag_t              unit_tag;
  logic [DW-1:0]         unit_dist;
  logic                  unit_busy;

  // Coordinate trimming and distance widening.
  logic [COORD_BITS+COORD_IN_W-1:0] x_ext, y_ext;
  logic [DW+DIST_OUT_W-1:0]         dist_pad;
  logic                             cfg_wr;

  // Configuration register access.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[CFG_ADDR_W-1:2] == REG_CITY_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      city_count_r <= CITY_COUNT_RST;
    end else if (cfg_wr) begin
      city_count_r <= pwdata[CITY_W-1:0];
    end
  end

  always_comb begin
    if (paddr[CFG_ADDR_W-1:2] == REG_CITY_COUNT) begin
      prdata = {{(CFG_DATA_W-CITY_W){1'b0}}, city_count_r};
    end else begin
      prdata = '0;
    end
  end

  // Effective tour size, clamped to one and to the store depth.
  always_comb begin
    if (city_count_r == '0) begin
      n_eff = NW'(1);
    end else if (city_count_r > CITY_W'(MAX_CITIES)) begin
      n_eff = NW'(MAX_CITIES);
    end else begin
      n_eff = NW'(city_count_r);
    end
  end

  // Load slot, held at the last entry once the store is full.
  assign slot     = (load_cnt_r >= NW'(MAX_CITIES - 1)) ? IW'(MAX_CITIES - 1)
                                                        : load_cnt_r[IW-1:0];
  assign slot_inc = NW'(slot) + NW'(1);

  // Keep the low coordinate bits of each city.
  assign x_ext     = {{COORD_BITS{1'b0}}, in_x_coord};
  assign y_ext     = {{COORD_BITS{1'b0}}, in_y_coord};
  assign ram_wdata = {x_ext[COORD_BITS-1:0], y_ext[COORD_BITS-1:0]};
  assign rd_x      = ram_rdata[RW-1:COORD_BITS];
  assign rd_y      = ram_rdata[COORD_BITS-1:0];

  assign dist_pad  = {{DIST_OUT_W{1'b0}}, best_dist_r};
  assign out_free  = !out_valid_r || out_ready;

  // Coordinate store.
  nnt_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_CITIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared squared-distance unit.
  nnt_dist_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .tag_i  (tag_r),
    .ax_i   (cur_x_r),
    .ay_i   (cur_y_r),
    .bx_i   (rd_x),
    .by_i   (rd_y),
    .tag_o  (unit_tag),
    .dist_o (unit_dist),
    .busy_o (unit_busy)
  );

  // Sequencer state and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      load_cnt_r  <= '0;
      visited_r   <= '0;
      scan_r      <= '0;
      hop_r       <= '0;
      best_dist_r <= '1;
      best_city_r <= '0;
      found_r     <= 1'b0;
      tag_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      visited_r   <= visited_nxt;
      scan_r      <= scan_nxt;
      hop_r       <= hop_nxt;
      best_dist_r <= best_dist_nxt;
      best_city_r <= best_city_nxt;
      found_r     <= found_nxt;
      tag_r       <= tag_nxt;
      out_valid_r <= push ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    end
  end

  // Current city coordinates and result payload.
  always_ff @(posedge clk) begin
    cur_x_r <= cur_x_nxt;
    cur_y_r <= cur_y_nxt;
    if (push) begin
      out_city_r <= push_city;
      out_dist_r <= push_dist;
      out_end_r  <= push_end;
    end
  end

  // Next state and outputs of the sequencer.
  always_comb begin
    state_nxt     = state_r;
    load_cnt_nxt  = load_cnt_r;
    visited_nxt   = visited_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    scan_nxt      = scan_r;
    hop_nxt       = hop_r;
    best_dist_nxt = best_dist_r;
    best_city_nxt = best_city_r;
    found_nxt     = found_r;
    tag_nxt       = '0;
    ram_we        = 1'b0;
    ram_raddr     = '0;
    in_ready      = 1'b0;
    push          = 1'b0;
    push_city     = '0;
    push_dist     = '0;
    push_end      = 1'b0;

    // Track the closest live candidate as results leave the distance unit.
    if ((state_r == S_SCAN || state_r == S_DRAIN) && unit_tag.vld && unit_tag.live &&
        (!found_r || unit_dist < best_dist_r)) begin
      found_nxt     = 1'b1;
      best_dist_nxt = unit_dist;
      best_city_nxt = unit_tag.idx[IW-1:0];
    end

    unique case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ram_we       = 1'b1;
          load_cnt_nxt = slot_inc;
          if (slot_inc >= n_eff) begin
            load_cnt_nxt = '0;
            state_nxt    = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        // Tour opens at city 0 with a zero distance.
        if (out_free) begin
          push        = 1'b1;
          visited_nxt = MAX_CITIES'(1);
          hop_nxt     = NW'(1);
          state_nxt   = S_CUR;
        end
      end
      S_CUR: begin
        cur_x_nxt = rd_x;
        cur_y_nxt = rd_y;
        found_nxt = 1'b0;
        scan_nxt  = IW'(1);
        state_nxt = (hop_r == n_eff) ? S_RET : S_SCAN;
      end
      S_SCAN: begin
        ram_raddr    = scan_r;
        tag_nxt.vld  = 1'b1;
        tag_nxt.live = !visited_r[scan_r];
        tag_nxt.idx  = CITY_W'(scan_r);
        scan_nxt     = scan_r + IW'(1);
        if (NW'(scan_r) == n_eff - NW'(1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!tag_r.vld && !unit_busy) begin
          state_nxt = S_HOP;
        end
      end
      S_HOP: begin
        ram_raddr = best_city_r;
        if (out_free) begin
          push                     = 1'b1;
          push_city                = CITY_W'(best_city_r);
          push_dist                = dist_pad[DIST_OUT_W-1:0];
          visited_nxt[best_city_r] = 1'b1;
          hop_nxt                  = hop_r + NW'(1);
          state_nxt                = S_CUR;
        end
      end
      S_RET: begin
        // Distance from the last city back to city 0.
        tag_nxt.vld  = 1'b1;
        tag_nxt.live = 1'b1;
        state_nxt    = S_RWAIT;
      end
      S_RWAIT: begin
        if (unit_tag.vld) begin
          best_dist_nxt = unit_dist;
          state_nxt     = S_REMIT;
        end
      end
      S_REMIT: begin
        if (out_free) begin
          push      = 1'b1;
          push_dist = dist_pad[DIST_OUT_W-1:0];
          push_end  = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_city_index  = out_city_r;
  assign out_hop_dist_sq = out_dist_r;
  assign out_tour_end    = out_end_r;

`ifndef ASSERT_OFF
  // No distance work may be in flight while cities are being loaded.
  a_idle_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!unit_busy && !tag_r.vld))
    else $error("distance pipeline busy during loading");

  // A hop is only emitted for a city that was found and not yet visited.
  a_hop_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HOP && out_free) |-> (found_r && !visited_r[best_city_r]))
    else $error("hop to a visited or missing city");

  // The origin stays marked for the whole scan.
  a_origin_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> visited_r[0])
    else $error("city 0 not marked during scan");

  // The closing transaction always names city 0.
  a_end_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_end_r) |-> (out_city_r == '0))
    else $error("tour end not at city 0");
`endif

endmodule
